// ===== rtl/linreg_gradient_descent_trainer_macros.svh =====
// Assertion macros used by the checker in lgd_chk.sv
`ifndef LINREG_GRADIENT_DESCENT_TRAINER_MACROS_SVH
`define LINREG_GRADIENT_DESCENT_TRAINER_MACROS_SVH

// Same-cycle implication, reset masks the check
`define LGD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check
`define LGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lgd_pkg.sv =====
package lgd_pkg;

    localparam int NF   = 5;
    localparam int IW   = (NF > 1) ? $clog2(NF) : 1;
    localparam int XW   = 16;
    localparam int WW   = 32;
    localparam int EW   = 28;
    localparam int AW   = 33;
    localparam int BW   = 29;
    localparam int PW   = AW + BW;
    localparam int GW   = 64;
    localparam int DW   = 16;
    localparam int CHW  = 24;
    localparam int ACCW = 88;
    localparam int PRW  = 52;
    localparam int CIW  = 8;

    // configuration register indexes
    localparam logic [CIW-1:0] CFG_LEARNING_RATE  = 8'd0;
    localparam logic [CIW-1:0] CFG_LOSS_THRESHOLD = 8'd1;
    localparam logic [CIW-1:0] CFG_SAMPLE_COUNT   = 8'd2;
    localparam logic [CIW-1:0] CFG_MAX_EPOCHS     = 8'd3;

    localparam logic [23:0] RST_LEARNING_RATE  = 24'd167772;
    localparam logic [31:0] RST_LOSS_THRESHOLD = 32'd167772;
    localparam logic [15:0] RST_SAMPLE_COUNT   = 16'd1000;
    localparam logic [15:0] RST_MAX_EPOCHS     = 16'd10000;

    // what a multiplier product is used for
    typedef enum logic [1:0] {
        K_DOT  = 2'd0,
        K_SQ   = 2'd1,
        K_GRAD = 2'd2,
        K_STEP = 2'd3
    } t_kind;

    typedef struct packed {
        logic          vld;
        t_kind         kind;
        logic [IW-1:0] idx;
        logic [1:0]    chunk;
    } t_mtag;

endpackage

// ===== rtl/linreg_gradient_descent_trainer.sv =====
// Full-batch gradient descent trainer for a five-weight linear regressor on mean
// squared error. One shared 33x29 signed multiplier computes the dot product,
// the squared error and the gradient terms of each sample; o_in_stall is high
// from acceptance of a sample until the block is ready again. The sample that
// closes an epoch adds the epoch update: a bit-serial 64-by-16 divider forms the
// mean loss and the five mean gradients, and three multiplier passes per weight
// scale each gradient by the learning rate. The result is held in an output
// register until taken; the block waits only if an earlier result is still held.
// After a result with the stop flag set, samples are accepted and dropped until
// reset. Configuration is always ready and takes effect at once.
module linreg_gradient_descent_trainer import lgd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [XW-1:0]  i_feature_0,
    input  logic signed [XW-1:0]  i_feature_1,
    input  logic signed [XW-1:0]  i_feature_2,
    input  logic signed [XW-1:0]  i_feature_3,
    input  logic signed [XW-1:0]  i_feature_4,
    input  logic signed [XW-1:0]  i_target_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_epoch_number,
    output logic [31:0]           o_mean_loss,
    output logic signed [WW-1:0]  o_weight_0,
    output logic signed [WW-1:0]  o_weight_1,
    output logic signed [WW-1:0]  o_weight_2,
    output logic signed [WW-1:0]  o_weight_3,
    output logic signed [WW-1:0]  o_weight_4,
    output logic                  o_stop_flag,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CIW-1:0]        i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DOT   = 14'b00000000000010,
        S_DOTW  = 14'b00000000000100,
        S_ERR   = 14'b00000000001000,
        S_SQ    = 14'b00000000010000,
        S_GRAD  = 14'b00000000100000,
        S_GRADW = 14'b00000001000000,
        S_CNT   = 14'b00000010000000,
        S_DIVL  = 14'b00000100000000,
        S_DIVLW = 14'b00001000000000,
        S_DIVG  = 14'b00010000000000,
        S_DIVGW = 14'b00100000000000,
        S_STEP  = 14'b01000000000000,
        S_UPD   = 14'b10000000000000
    } t_state;

    t_state                r_state;
    logic [23:0]           r_lr;
    logic [31:0]           r_thr;
    logic [15:0]           r_scnt;
    logic [15:0]           r_maxep;
    logic signed [WW-1:0]  r_w [NF];
    logic signed [GW-1:0]  r_grad [NF];
    logic signed [XW-1:0]  r_x [NF];
    logic signed [XW-1:0]  r_t;
    logic [GW-1:0]         r_loss;
    logic [15:0]           r_samples;
    logic [15:0]           r_epochs;
    logic                  r_fin;
    logic signed [PRW-1:0] r_pred;
    logic signed [EW-1:0]  r_err;
    logic [IW-1:0]         r_idx;
    logic [1:0]            r_chunk;
    logic [GW-1:0]         r_mean;
    logic [GW-1:0]         r_g;
    logic                  r_neg;
    logic [ACCW-1:0]       r_acc;
    logic                  r_out_valid;
    logic [15:0]           r_o_epoch;
    logic [31:0]           r_o_loss;
    logic signed [WW-1:0]  r_o_w [NF];
    logic                  r_o_stop;

    t_mtag                 mul_tag;
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    t_mtag                 prod_tag;
    logic signed [PW-1:0]  prod;
    logic                  div_start;
    logic [GW-1:0]         div_num;
    logic                  div_done;
    logic [GW-1:0]         div_quo;
    logic [15:0]           eff_cnt;
    logic [16:0]           n_samples;
    logic [15:0]           n_epochs;
    logic [GW:0]           loss_sum;
    logic [CHW-1:0]        chunk_val;
    logic [GW-1:0]         step;
    logic signed [GW+1:0]  n_w;
    logic signed [WW-1:0]  w_sat;
    logic                  out_free;
    logic signed [GW-1:0]  cur_grad;

    lgd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (mul_tag),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_tag   (prod_tag),
        .o_prod  (prod)
    );

    lgd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (eff_cnt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // pick multiplier operands for the current step
    always_comb begin
        mul_tag       = '0;
        mul_tag.kind  = K_DOT;
        mul_tag.idx   = r_idx;
        mul_tag.chunk = r_chunk;
        mul_a         = AW'(r_err);
        mul_b         = BW'(r_x[r_idx]);
        case (r_chunk)
            2'd0:    chunk_val = r_g[CHW-1:0];
            2'd1:    chunk_val = r_g[2*CHW-1:CHW];
            default: chunk_val = CHW'(r_g[GW-1:2*CHW]);
        endcase
        case (r_state)
            S_DOT: begin
                mul_tag.vld  = 1'b1;
                mul_tag.kind = K_DOT;
                mul_a        = AW'(r_w[r_idx]);
            end
            S_SQ: begin
                mul_tag.vld  = 1'b1;
                mul_tag.kind = K_SQ;
                mul_b        = BW'(r_err);
            end
            S_GRAD: begin
                mul_tag.vld  = 1'b1;
                mul_tag.kind = K_GRAD;
            end
            S_STEP: begin
                mul_tag.vld  = 1'b1;
                mul_tag.kind = K_STEP;
                mul_a        = $signed({{(AW-CHW){1'b0}}, chunk_val});
                mul_b        = $signed({{(BW-24){1'b0}}, r_lr});
            end
            default: ;
        endcase
    end

    // epoch bookkeeping and weight update arithmetic
    always_comb begin
        eff_cnt   = (r_scnt == 16'd0) ? 16'd1 : r_scnt;
        n_samples = {1'b0, r_samples} + 17'd1;
        n_epochs  = r_epochs + 16'd1;
        cur_grad  = r_grad[r_idx];
        div_start = (r_state == S_DIVL) || (r_state == S_DIVG);
        div_num   = (r_state == S_DIVL) ? r_loss
                  : (cur_grad[GW-1] ? (GW'(0) - GW'(cur_grad)) : GW'(cur_grad));
        loss_sum  = {1'b0, r_loss} + (GW+1)'(prod[PW-2:0]);
        step      = r_acc[ACCW-1:CHW];
        n_w       = (GW+2)'(r_w[r_idx])
                  + (r_neg ? $signed({2'b00, step}) : -$signed({2'b00, step}));
        if (n_w > (GW+2)'($signed(32'h7FFFFFFF))) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (n_w < (GW+2)'($signed(32'h80000000))) begin
            w_sat = $signed(32'h80000000);
        end else begin
            w_sat = n_w[WW-1:0];
        end
        out_free = !r_out_valid || !i_out_stall;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= RST_LEARNING_RATE;
            r_thr   <= RST_LOSS_THRESHOLD;
            r_scnt  <= RST_SAMPLE_COUNT;
            r_maxep <= RST_MAX_EPOCHS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEARNING_RATE:  r_lr    <= i_cfg_data[23:0];
                CFG_LOSS_THRESHOLD: r_thr   <= i_cfg_data;
                CFG_SAMPLE_COUNT:   r_scnt  <= i_cfg_data[15:0];
                CFG_MAX_EPOCHS:     r_maxep <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_chunk     <= '0;
            r_loss      <= '0;
            r_samples   <= '0;
            r_epochs    <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < NF; j++) begin
                r_w[j]    <= '0;
                r_grad[j] <= '0;
            end
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    // take a sample; drop it once training has stopped
                    if (i_in_valid && !r_fin) begin
                        r_state <= S_DOT;
                        r_idx   <= '0;
                    end
                end
                S_DOT: begin
                    if (r_idx == IW'(NF - 1)) begin
                        r_state <= S_DOTW;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DOTW: r_state <= S_ERR;
                S_ERR: begin
                    r_err   <= EW'(r_pred >>> 24) - EW'(r_t);
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_idx   <= '0;
                    r_state <= S_GRAD;
                end
                S_GRAD: begin
                    if (r_idx == IW'(NF - 1)) begin
                        r_state <= S_GRADW;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_GRADW: r_state <= S_CNT;
                S_CNT: begin
                    if (n_samples >= {1'b0, eff_cnt}) begin
                        r_state <= S_DIVL;
                    end else begin
                        r_samples <= n_samples[15:0];
                        r_state   <= S_IDLE;
                    end
                end
                S_DIVL: r_state <= S_DIVLW;
                S_DIVLW: begin
                    if (div_done) begin
                        r_mean  <= div_quo;
                        r_idx   <= '0;
                        r_state <= S_DIVG;
                    end
                end
                S_DIVG: begin
                    r_neg   <= cur_grad[GW-1];
                    r_state <= S_DIVGW;
                end
                S_DIVGW: begin
                    if (div_done) begin
                        r_g     <= div_quo;
                        r_acc   <= '0;
                        r_chunk <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    // last chunk product lands in the cycle after
                    if (r_chunk == 2'd2) begin
                        r_state <= S_UPD;
                    end else begin
                        r_chunk <= r_chunk + 2'd1;
                    end
                end
                S_UPD: begin
                    if (prod_tag.vld) begin
                        // wait for the last chunk product
                    end else if (r_idx != IW'(NF - 1)) begin
                        r_w[r_idx]    <= w_sat;
                        r_grad[r_idx] <= '0;
                        r_idx         <= r_idx + IW'(1);
                        r_state       <= S_DIVG;
                    end else if (out_free) begin
                        r_w[r_idx]    <= w_sat;
                        r_grad[r_idx] <= '0;
                        r_out_valid   <= 1'b1;
                        r_o_epoch     <= n_epochs;
                        r_o_loss      <= (r_mean > GW'(32'hFFFFFFFF)) ? 32'hFFFFFFFF
                                                                  : r_mean[31:0];
                        for (int j = 0; j < NF - 1; j++) begin
                            r_o_w[j] <= r_w[j];
                        end
                        r_o_w[NF-1] <= w_sat;
                        r_o_stop    <= (r_mean < GW'(r_thr)) || (n_epochs >= r_maxep);
                        r_fin       <= (r_mean < GW'(r_thr)) || (n_epochs >= r_maxep);
                        r_epochs    <= n_epochs;
                        r_loss      <= '0;
                        r_samples   <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // fold in the multiplier result of the previous cycle
            if (prod_tag.vld) begin
                case (prod_tag.kind)
                    K_SQ: begin
                        r_loss <= loss_sum[GW] ? '1 : loss_sum[GW-1:0];
                    end
                    K_GRAD: begin
                        r_grad[prod_tag.idx] <= r_grad[prod_tag.idx]
                                              + (GW'(prod) <<< 1);
                    end
                    K_STEP: begin
                        r_acc <= r_acc + (ACCW'(prod[2*CHW-1:0])
                                          << (CHW * prod_tag.chunk));
                    end
                    default: ;
                endcase
            end
        end
    end

    // sample capture and dot product accumulation
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_x[0] <= i_feature_0;
            r_x[1] <= i_feature_1;
            r_x[2] <= i_feature_2;
            r_x[3] <= i_feature_3;
            r_x[4] <= i_feature_4;
            r_t    <= i_target_value;
            r_pred <= '0;
        end else if (prod_tag.vld && prod_tag.kind == K_DOT) begin
            r_pred <= r_pred + PRW'(prod);
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_epoch_number = r_o_epoch;
    assign o_mean_loss    = r_o_loss;
    assign o_weight_0     = r_o_w[0];
    assign o_weight_1     = r_o_w[1];
    assign o_weight_2     = r_o_w[2];
    assign o_weight_3     = r_o_w[3];
    assign o_weight_4     = r_o_w[4];
    assign o_stop_flag    = r_o_stop;

endmodule

// ===== rtl/lgd_mul.sv =====
module lgd_mul import lgd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mtag                i_tag,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output t_mtag                o_tag,
    output logic signed [PW-1:0] o_prod
);

    t_mtag                r_tag;
    logic signed [PW-1:0] r_prod;

    // register the product with its tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
        r_prod <= PW'(i_a) * PW'(i_b);
    end

    assign o_tag  = r_tag;
    assign o_prod = r_prod;

endmodule

// ===== rtl/lgd_div.sv =====
module lgd_div import lgd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [GW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [GW-1:0] o_quo
);

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [GW-1:0] r_quo;
    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_nx;

    // one restoring step per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[GW-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[GW-2:0], ge};
            r_rem <= rem_nx[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/lgd_chk.sv =====
`include "linreg_gradient_descent_trainer_macros.svh"

module lgd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_epoch_number,
    input logic [31:0] o_mean_loss
);

    // a result only appears at the end of sample work
    `LGD_ASSERT_NOW(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without sample work")

    // epochs count from one and stop before wrapping
    `LGD_ASSERT_NOW(a_epoch_nonzero, i_clk, i_rst_n, o_out_valid, o_epoch_number != 16'd0, "zero epoch number")

    // a held result keeps its loss
    `LGD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_mean_loss), "stalled result changed")

endmodule

bind linreg_gradient_descent_trainer lgd_chk u_lgd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_epoch_number (o_epoch_number),
    .o_mean_loss    (o_mean_loss)
);

// ===== tb/sv/lgd_epoch_checker.sv =====
`timescale 1ns / 1ps

module lgd_epoch_checker import lgd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic signed [XW-1:0]  i_feature_0,
    input  logic signed [XW-1:0]  i_feature_1,
    input  logic signed [XW-1:0]  i_feature_2,
    input  logic signed [XW-1:0]  i_feature_3,
    input  logic signed [XW-1:0]  i_feature_4,
    input  logic signed [XW-1:0]  i_target_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [15:0]           i_epoch_number,
    input  logic [31:0]           i_mean_loss,
    input  logic signed [WW-1:0]  i_weight_0,
    input  logic signed [WW-1:0]  i_weight_1,
    input  logic signed [WW-1:0]  i_weight_2,
    input  logic signed [WW-1:0]  i_weight_3,
    input  logic signed [WW-1:0]  i_weight_4,
    input  logic                  i_stop_flag,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CIW-1:0]        i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output int                    o_fail_count,
    output int                    o_reports_due,
    output int                    o_samples_taken,
    output int                    o_reports_taken
);

    typedef struct {
        logic [15:0]          epoch;
        logic [31:0]          loss;
        logic signed [WW-1:0] wt [NF];
        logic                 stop;
    } t_epoch_report;

    t_epoch_report epoch_reports_due [$];

    // predicted trainer state
    logic [23:0]          step_rate;
    logic [31:0]          stop_loss;
    logic [15:0]          batch_len;
    logic [15:0]          epoch_cap;
    logic signed [WW-1:0] weight_q [NF];
    logic signed [63:0]   grad_acc [NF];
    logic [63:0]          loss_acc;
    logic [15:0]          batch_pos;
    logic [15:0]          epoch_cnt;
    logic                 halted;

    logic signed [XW-1:0] cur_x [NF];
    logic signed [XW-1:0] cur_t;

    // close the epoch: average, step the weights, queue the report
    task automatic close_epoch();
        logic [63:0]        n, mean, mag, g, step;
        logic signed [65:0] nw;
        logic               neg;
        t_epoch_report      r;
        n = (batch_len == 0) ? 64'd1 : 64'(batch_len);
        mean = loss_acc / n;
        epoch_cnt = epoch_cnt + 16'd1;
        for (int j = 0; j < NF; j++) begin
            neg = grad_acc[j] < 0;
            mag = neg ? 64'(-grad_acc[j]) : 64'(grad_acc[j]);
            g = mag / n;
            step = (g >> 24) * 64'(step_rate) + (((g & 64'hFFFFFF) * 64'(step_rate)) >> 24);
            nw = weight_q[j];
            nw = neg ? nw + $signed({2'b00, step}) : nw - $signed({2'b00, step});
            if (nw > 66'sd2147483647) nw = 66'sd2147483647;
            if (nw < -66'sd2147483648) nw = -66'sd2147483648;
            weight_q[j] = nw[31:0];
            grad_acc[j] = 0;
            r.wt[j] = weight_q[j];
        end
        halted = (mean < 64'(stop_loss)) || (epoch_cnt >= epoch_cap);
        r.epoch = epoch_cnt;
        r.loss = (mean > 64'hFFFFFFFF) ? 32'hFFFFFFFF : mean[31:0];
        r.stop = halted;
        epoch_reports_due.push_back(r);
        loss_acc = 0;
        batch_pos = 0;
    endtask

    // accumulate one sample's loss and gradient
    task automatic train_on_sample();
        longint     pred, err;
        logic [63:0] sq;
        logic [64:0] sum;
        logic [63:0] n;
        if (halted) return;
        pred = 0;
        for (int j = 0; j < NF; j++)
            pred += longint'(weight_q[j]) * longint'(cur_x[j]);
        err = (pred >>> 24) - longint'(cur_t);
        sq = err * err;
        sum = {1'b0, loss_acc} + {1'b0, sq};
        loss_acc = sum[64] ? 64'hFFFFFFFFFFFFFFFF : sum[63:0];
        for (int j = 0; j < NF; j++)
            grad_acc[j] += 2 * err * longint'(cur_x[j]);
        batch_pos = batch_pos + 16'd1;
        n = (batch_len == 0) ? 64'd1 : 64'(batch_len);
        if (64'(batch_pos) >= n) close_epoch();
    endtask

    function automatic int check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_epoch_report r;
        int bad;
        if (!i_rst_n) begin
            step_rate = RST_LEARNING_RATE;
            stop_loss = RST_LOSS_THRESHOLD;
            batch_len = RST_SAMPLE_COUNT;
            epoch_cap = RST_MAX_EPOCHS;
            for (int j = 0; j < NF; j++) begin
                weight_q[j] = 0;
                grad_acc[j] = 0;
            end
            loss_acc = 0;
            batch_pos = 0;
            epoch_cnt = 0;
            halted = 0;
            epoch_reports_due.delete();
            o_fail_count = 0;
            o_samples_taken = 0;
            o_reports_taken = 0;
        end else begin
            // compare a taken report against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                o_reports_taken++;
                if (epoch_reports_due.size() == 0) begin
                    $display("%0t: report with none expected, epoch actual %0d",
                             $time, i_epoch_number);
                    o_fail_count++;
                end else begin
                    r = epoch_reports_due.pop_front();
                    bad = 0;
                    bad += check_field("epoch_number", 64'(r.epoch), 64'(i_epoch_number));
                    bad += check_field("mean_loss", 64'(r.loss), 64'(i_mean_loss));
                    bad += check_field("weight_0", 64'(r.wt[0]), 64'(i_weight_0));
                    bad += check_field("weight_1", 64'(r.wt[1]), 64'(i_weight_1));
                    bad += check_field("weight_2", 64'(r.wt[2]), 64'(i_weight_2));
                    bad += check_field("weight_3", 64'(r.wt[3]), 64'(i_weight_3));
                    bad += check_field("weight_4", 64'(r.wt[4]), 64'(i_weight_4));
                    bad += check_field("stop_flag", 64'(r.stop), 64'(i_stop_flag));
                    if (bad != 0) o_fail_count++;
                end
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEARNING_RATE:  step_rate = i_cfg_data[23:0];
                    CFG_LOSS_THRESHOLD: stop_loss = i_cfg_data;
                    CFG_SAMPLE_COUNT:   batch_len = i_cfg_data[15:0];
                    CFG_MAX_EPOCHS:     epoch_cap = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // sample requests
            if (i_in_valid && !i_in_stall) begin
                o_samples_taken++;
                cur_x[0] = i_feature_0;
                cur_x[1] = i_feature_1;
                cur_x[2] = i_feature_2;
                cur_x[3] = i_feature_3;
                cur_x[4] = i_feature_4;
                cur_t = i_target_value;
                train_on_sample();
            end
        end
        o_reports_due = epoch_reports_due.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lgd_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_SAMPLES = 950;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_stall;
    logic signed [XW-1:0] i_feat [NF];
    logic signed [XW-1:0] i_target_value = 0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1;
    logic [15:0]          o_epoch_number;
    logic [31:0]          o_mean_loss;
    logic signed [WW-1:0] o_weight [NF];
    logic                 o_stop_flag;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic [CIW-1:0]       i_cfg_index = 0;
    logic [31:0]          i_cfg_data = 0;

    int  fail_count, reports_due, samples_taken, reports_taken;
    int  cycle_cnt = 0;
    int  out_hold = 0;
    bit  quiet = 0;

    initial for (int j = 0; j < NF; j++) i_feat[j] = 0;

    always #2 i_clk = ~i_clk;

    linreg_gradient_descent_trainer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_feature_0(i_feat[0]), .i_feature_1(i_feat[1]), .i_feature_2(i_feat[2]),
        .i_feature_3(i_feat[3]), .i_feature_4(i_feat[4]),
        .i_target_value(i_target_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_epoch_number(o_epoch_number), .o_mean_loss(o_mean_loss),
        .o_weight_0(o_weight[0]), .o_weight_1(o_weight[1]), .o_weight_2(o_weight[2]),
        .o_weight_3(o_weight[3]), .o_weight_4(o_weight[4]),
        .o_stop_flag(o_stop_flag),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    lgd_epoch_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_feature_0(i_feat[0]), .i_feature_1(i_feat[1]), .i_feature_2(i_feat[2]),
        .i_feature_3(i_feat[3]), .i_feature_4(i_feat[4]),
        .i_target_value(i_target_value),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_epoch_number(o_epoch_number), .i_mean_loss(o_mean_loss),
        .i_weight_0(o_weight[0]), .i_weight_1(o_weight[1]), .i_weight_2(o_weight[2]),
        .i_weight_3(o_weight[3]), .i_weight_4(o_weight[4]),
        .i_stop_flag(o_stop_flag),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_reports_due(reports_due),
        .o_samples_taken(samples_taken), .o_reports_taken(reports_taken)
    );

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    // after each taken report, hold the output stall for a random number of cycles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            out_hold = quiet ? 0 : $urandom_range(0, 10);
            i_out_stall <= (out_hold != 0);
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= (out_hold != 0);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // random field: full range mostly, else small or extreme values
    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 511)) - 16'd256;
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_sample(logic [15:0] f0, f1, f2, f3, f4, tv);
        int  gap;
        bit  held;
        gap = quiet ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_feat[0] = f0;
        i_feat[1] = f1;
        i_feat[2] = f2;
        i_feat[3] = f3;
        i_feat[4] = f4;
        i_target_value = tv;
        // stall only moves at the rising edge, so its value now holds for the next one
        forever begin
            held = o_in_stall;
            @(posedge i_clk);
            if (!held) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_random_sample();
        send_sample(pick_field(), pick_field(), pick_field(), pick_field(),
                    pick_field(), pick_field());
    endtask

    task automatic cfg_write(logic [CIW-1:0] idx, logic [31:0] data);
        bit ok;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            ok = o_cfg_ready;
            @(posedge i_clk);
            if (ok) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // drain outstanding reports, then let any sample in flight finish
    task automatic settle();
        while (reports_due != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        int sent;
        int burst;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // largest step, one sample per epoch (zero count acts as one)
        cfg_write(CFG_LOSS_THRESHOLD, 32'd0);
        cfg_write(CFG_MAX_EPOCHS, 32'hFFFF);
        cfg_write(CFG_LEARNING_RATE, 32'hFFFFFF);
        cfg_write(CFG_SAMPLE_COUNT, 32'd0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h1000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();

        // zero step with the largest count, then lower the count mid-epoch
        cfg_write(CFG_LEARNING_RATE, 32'd0);
        cfg_write(CFG_SAMPLE_COUNT, 32'hFFFF);
        repeat (3) send_random_sample();
        settle();
        cfg_write(CFG_SAMPLE_COUNT, 32'd2);
        send_random_sample();
        settle();

        // writes to unknown indexes must do nothing
        cfg_write(8'd4, 32'hFFFFFFFF);
        cfg_write(8'hFF, 32'h12345678);
        cfg_write(CFG_LEARNING_RATE, 32'd167772);
        repeat (4) send_random_sample();
        settle();

        // random phases of settings and sample bursts
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0: cfg_write(CFG_LEARNING_RATE, $urandom());
                1: cfg_write(CFG_LEARNING_RATE, 32'($urandom_range(0, 4096)));
                2: cfg_write(CFG_LEARNING_RATE, 32'hFFFFFF);
                default: cfg_write(CFG_LEARNING_RATE, 32'($urandom_range(0, 200000)));
            endcase
            if ($urandom_range(0, 7) == 0)
                cfg_write(CFG_SAMPLE_COUNT, 32'd0);
            else
                cfg_write(CFG_SAMPLE_COUNT, {16'($urandom()), 16'($urandom_range(1, 7))});
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_MAX_EPOCHS, {16'($urandom()), 16'($urandom_range(40000, 65535))});
            if ($urandom_range(0, 5) == 0)
                cfg_write(CFG_LOSS_THRESHOLD, {16'($urandom()), 16'h0000});
            cfg_write(CFG_LOSS_THRESHOLD, 32'd0);
            burst = $urandom_range(5, 40);
            repeat (burst) send_random_sample();
            sent += burst;
            settle();
        end

        // stop on the first epoch: loss below the top threshold, zero epoch cap
        quiet = 0;
        cfg_write(CFG_SAMPLE_COUNT, 32'd1);
        cfg_write(CFG_LOSS_THRESHOLD, 32'hFFFFFFFF);
        cfg_write(CFG_MAX_EPOCHS, 32'd0);
        repeat (6) send_random_sample();
        settle();
        repeat (500) @(negedge i_clk);

        $display("%0d samples accepted, %0d epoch reports checked, %0d cycles",
                 samples_taken, reports_taken, cycle_cnt);
        $display("covered extreme features, step sizes, counts, lowered count and stop");
        if (fail_count == 0 && reports_due == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures, %0d reports missing", fail_count, reports_due);
            $display("status: fail");
        end
        $finish;
    end

endmodule
